// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file mjpe_checker.sv.
// Expects clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is low.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");

// Next-cycle implication, masked while reset is low.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");

`endif

// ===== rtl/mjpe_pkg.sv =====
`timescale 1ns / 1ps
// Minimum-jerk evaluator package: widths, constants, stage record types and
// the per-stage step functions. No dependencies.
package mjpe_pkg;

  localparam int DATA_W        = 32;
  localparam int S_BITS        = 30;            // fraction bits of normalized time
  localparam int S_W           = S_BITS + 1;    // s in [0, 2^30]
  localparam int QUO_W         = DATA_W - 1;    // quotient bits below saturation
  localparam int POLY_W        = 40;
  localparam int MAGA_W        = DATA_W + 1;    // |P''| needs one more bit
  localparam int DSQ_W         = 2 * DATA_W;
  localparam int PROD_W        = 2 * DATA_W;
  localparam int PRA_W         = MAGA_W + DATA_W;
  localparam int WIDE_W        = DATA_W + 4;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic signed [POLY_W-1:0] C6   = POLY_W'(6);
  localparam logic signed [POLY_W-1:0] C10  = POLY_W'(10);
  localparam logic signed [POLY_W-1:0] C15  = POLY_W'(15);
  localparam logic signed [POLY_W-1:0] C30  = POLY_W'(30);
  localparam logic signed [POLY_W-1:0] C60  = POLY_W'(60);
  localparam logic signed [POLY_W-1:0] C120 = POLY_W'(120);
  localparam logic signed [POLY_W-1:0] C180 = POLY_W'(180);

  localparam logic signed [WIDE_W-1:0] SAT_HI  = WIDE_W'(2147483647);
  localparam logic signed [WIDE_W-1:0] SAT_LO  = ~SAT_HI;
  localparam logic [DATA_W-1:0]        MAG_OVF = {1'b1, {(DATA_W-1){1'b0}}};

  // normalized-time divider stages
  typedef struct packed {
    logic signed [DATA_W-1:0] start;
    logic [DATA_W-1:0]        dmag;
    logic                     dneg;
    logic [DATA_W-1:0]        dur;
    logic                     err;
    logic [DATA_W-1:0]        rem;
    logic [S_W-1:0]           quo;
  } sdiv_t;

  // power stages
  typedef struct packed {
    logic signed [DATA_W-1:0] start;
    logic [DATA_W-1:0]        dmag;
    logic                     dneg;
    logic [DATA_W-1:0]        dur;
    logic [DSQ_W-1:0]         dsq;
    logic                     err;
    logic [S_W-1:0]           s1;
    logic [S_W-1:0]           s2;
    logic [S_W-1:0]           s3;
    logic [S_W-1:0]           s4;
    logic [S_W-1:0]           s5;
  } pow_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] start;
    logic [DATA_W-1:0]        dmag;
    logic                     dneg;
    logic [DATA_W-1:0]        dur;
    logic [DSQ_W-1:0]         dsq;
    logic                     err;
    logic signed [POLY_W-1:0] p;
    logic signed [POLY_W-1:0] dp;
    logic signed [POLY_W-1:0] ddp;
  } poly_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] start;
    logic [DATA_W-1:0]        dmag;
    logic [DATA_W-1:0]        dur;
    logic [DSQ_W-1:0]         dsq;
    logic                     err;
    logic [DATA_W-1:0]        mp;
    logic [DATA_W-1:0]        mv;
    logic [MAGA_W-1:0]        ma;
    logic                     np;
    logic                     nv;
    logic                     na;
  } mag_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] start;
    logic [DATA_W-1:0]        dur;
    logic [DSQ_W-1:0]         dsq;
    logic                     err;
    logic                     np;
    logic                     nv;
    logic                     na;
    logic [PROD_W-1:0]        prp;
    logic [PROD_W-1:0]        prv;
    logic [PRA_W-1:0]         pra;
  } prod_t;

  // velocity / acceleration quotient stages
  typedef struct packed {
    logic signed [DATA_W-1:0] pos;
    logic                     err;
    logic                     nv;
    logic                     na;
    logic                     ov_v;
    logic                     ov_a;
    logic [DATA_W-1:0]        dur;
    logic [DSQ_W-1:0]         dsq;
    logic [DATA_W-1:0]        rv;
    logic [DSQ_W-1:0]         ra;
    logic [QUO_W-1:0]         qv;
    logic [QUO_W-1:0]         qa;
    logic [QUO_W-1:0]         lv;
    logic [QUO_W-1:0]         la;
  } qdiv_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] pos;
    logic signed [DATA_W-1:0] vel;
    logic signed [DATA_W-1:0] acc;
    logic                     err;
  } res_t;

  // one restoring step of t * 2^30 / T
  function automatic sdiv_t sdiv_step(input sdiv_t x);
    sdiv_t           y;
    logic [DATA_W:0] r2;
    logic [DATA_W:0] diff;
    logic            ge;
    y    = x;
    r2   = {x.rem, 1'b0};
    diff = r2 - {1'b0, x.dur};
    ge   = (r2 >= {1'b0, x.dur});
    y.rem = ge ? diff[DATA_W-1:0] : r2[DATA_W-1:0];
    y.quo = {x.quo[S_W-2:0], ge};
    return y;
  endfunction

  // one restoring step for both the velocity and the acceleration quotient
  function automatic qdiv_t qdiv_step(input qdiv_t x);
    qdiv_t          y;
    logic [DATA_W:0] r2v;
    logic [DATA_W:0] dv;
    logic [DSQ_W:0]  r2a;
    logic [DSQ_W:0]  da;
    logic            gev;
    logic            gea;
    y    = x;
    r2v  = {x.rv, x.lv[QUO_W-1]};
    dv   = r2v - {1'b0, x.dur};
    gev  = (r2v >= {1'b0, x.dur});
    r2a  = {x.ra, x.la[QUO_W-1]};
    da   = r2a - {1'b0, x.dsq};
    gea  = (r2a >= {1'b0, x.dsq});
    y.rv = gev ? dv[DATA_W-1:0] : r2v[DATA_W-1:0];
    y.ra = gea ? da[DSQ_W-1:0] : r2a[DSQ_W-1:0];
    y.qv = {x.qv[QUO_W-2:0], gev};
    y.qa = {x.qa[QUO_W-2:0], gea};
    y.lv = {x.lv[QUO_W-2:0], 1'b0};
    y.la = {x.la[QUO_W-2:0], 1'b0};
    return y;
  endfunction

  // floor(a * b / 2^30) for a, b in [0, 2^30]
  function automatic logic [S_W-1:0] mul_frac(input logic [S_W-1:0] a,
                                               input logic [S_W-1:0] b);
    logic [2*S_W-1:0] pr;
    pr = {{S_W{1'b0}}, a} * {{S_W{1'b0}}, b};
    return pr[S_BITS+S_W-1:S_BITS];
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_word(input logic signed [WIDE_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[DATA_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[DATA_W-1:0];
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/minimum_jerk_point_evaluator.sv =====
`timescale 1ns / 1ps
// Minimum-jerk point evaluator, top level. Uses mjpe_pkg.
// Evaluates position, velocity and acceleration on a quintic minimum-jerk segment.
//
// Input channel in_*: valid/ready; an item is start, end, elapsed time t and
// duration T, all Q16.16 (FRAC_BITS fraction bits). Result channel out_*:
// position, velocity, acceleration (saturated) and time_error, set with zero
// motion outputs when T is zero or t > T.
// Throughput: one item per cycle while the spare register is empty. Depth is
// set by the restoring divider for s = t/T, four chained 31x31 power
// multipliers, a polynomial, magnitude and product stage, a setup stage and
// the 31-step dividers for /T and /T^2 that run side by side.
// Reset clears every valid bit; payload registers hold whatever they held.
// Stall: when out_ready is low the pipeline keeps moving until one more item
// lands in a spare register behind the output register; in_ready then drops
// and the whole pipeline holds until the result is taken. Nothing is lost or
// repeated.
module minimum_jerk_point_evaluator #(
  parameter int FRAC_BITS = mjpe_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [mjpe_pkg::DATA_W-1:0]  in_start_value,
  input  logic signed [mjpe_pkg::DATA_W-1:0]  in_end_value,
  input  logic [mjpe_pkg::DATA_W-1:0]         in_elapsed_time,
  input  logic [mjpe_pkg::DATA_W-1:0]         in_segment_duration,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [mjpe_pkg::DATA_W-1:0]  out_position,
  output logic signed [mjpe_pkg::DATA_W-1:0]  out_velocity,
  output logic signed [mjpe_pkg::DATA_W-1:0]  out_acceleration,
  output logic                                out_time_error
);

  localparam int DW    = mjpe_pkg::DATA_W;
  localparam int SD_N  = mjpe_pkg::S_BITS + 1;
  localparam int PW_N  = 4;
  localparam int QD_N  = mjpe_pkg::QUO_W + 1;
  localparam int NS    = SD_N + PW_N + 3 + QD_N;
  // product scaling: velocity >> (30 - F), acceleration << / >> |2F - 30|
  localparam int SHV   = mjpe_pkg::S_BITS - FRAC_BITS;
  localparam int SHL   = (2 * FRAC_BITS > mjpe_pkg::S_BITS) ?
                         2 * FRAC_BITS - mjpe_pkg::S_BITS : 0;
  localparam int SHR   = (2 * FRAC_BITS < mjpe_pkg::S_BITS) ?
                         mjpe_pkg::S_BITS - 2 * FRAC_BITS : 0;
  localparam int NA_W  = mjpe_pkg::PRA_W + SHL;
  localparam int QW    = mjpe_pkg::QUO_W;
  localparam int WW    = mjpe_pkg::WIDE_W;
  localparam int PW    = mjpe_pkg::POLY_W;

  logic [NS-1:0]     v_r;
  logic              en;
  logic              arrive;

  mjpe_pkg::sdiv_t   sd_r   [0:SD_N-1];
  mjpe_pkg::sdiv_t   sd_nxt [0:SD_N-1];
  mjpe_pkg::pow_t    pw_r   [0:PW_N-1];
  mjpe_pkg::pow_t    pw_nxt [0:PW_N-1];
  mjpe_pkg::poly_t   py_r, py_nxt;
  mjpe_pkg::mag_t    mg_r, mg_nxt;
  mjpe_pkg::prod_t   pr_r, pr_nxt;
  mjpe_pkg::qdiv_t   qd_r   [0:QD_N-1];
  mjpe_pkg::qdiv_t   qd_nxt [0:QD_N-1];

  mjpe_pkg::res_t    fin_res;
  mjpe_pkg::res_t    out_res_r, out_res_nxt;
  mjpe_pkg::res_t    spare_res_r, spare_res_nxt;
  logic              out_v_r, out_v_nxt;
  logic              spare_v_r, spare_v_nxt;

  // stage 0 and the normalized-time divider
  logic signed [DW:0] delta_c;
  logic signed [DW:0] delta_neg;
  logic               at_end;

  always_comb begin
    delta_c   = {in_end_value[DW-1], in_end_value} - {in_start_value[DW-1], in_start_value};
    delta_neg = -delta_c;
    at_end    = (in_elapsed_time == in_segment_duration);
    sd_nxt[0].start = in_start_value;
    sd_nxt[0].dneg  = delta_c[DW];
    sd_nxt[0].dmag  = delta_c[DW] ? delta_neg[DW-1:0] : delta_c[DW-1:0];
    sd_nxt[0].dur   = in_segment_duration;
    sd_nxt[0].err   = (in_segment_duration == '0) || (in_elapsed_time > in_segment_duration);
    // t <= T, so the top quotient bit is set only at t == T
    sd_nxt[0].rem   = at_end ? '0 : in_elapsed_time;
    sd_nxt[0].quo   = {{(mjpe_pkg::S_W-1){1'b0}}, at_end};
    for (int k = 1; k < SD_N; k++) begin
      sd_nxt[k] = mjpe_pkg::sdiv_step(sd_r[k-1]);
    end
  end

  // powers of s, and T^2 alongside
  always_comb begin
    pw_nxt[0]       = '0;
    pw_nxt[0].start = sd_r[SD_N-1].start;
    pw_nxt[0].dmag  = sd_r[SD_N-1].dmag;
    pw_nxt[0].dneg  = sd_r[SD_N-1].dneg;
    pw_nxt[0].dur   = sd_r[SD_N-1].dur;
    pw_nxt[0].err   = sd_r[SD_N-1].err;
    pw_nxt[0].dsq   = {{DW{1'b0}}, sd_r[SD_N-1].dur} * {{DW{1'b0}}, sd_r[SD_N-1].dur};
    pw_nxt[0].s1    = sd_r[SD_N-1].quo;
    pw_nxt[0].s2    = mjpe_pkg::mul_frac(sd_r[SD_N-1].quo, sd_r[SD_N-1].quo);
    pw_nxt[1]       = pw_r[0];
    pw_nxt[1].s3    = mjpe_pkg::mul_frac(pw_r[0].s2, pw_r[0].s1);
    pw_nxt[2]       = pw_r[1];
    pw_nxt[2].s4    = mjpe_pkg::mul_frac(pw_r[1].s3, pw_r[1].s1);
    pw_nxt[3]       = pw_r[2];
    pw_nxt[3].s5    = mjpe_pkg::mul_frac(pw_r[2].s4, pw_r[2].s1);
  end

  // P, P', P'' in Q30
  logic signed [PW-1:0] x1, x2, x3, x4, x5;

  always_comb begin
    x1 = {{(PW-mjpe_pkg::S_W){1'b0}}, pw_r[3].s1};
    x2 = {{(PW-mjpe_pkg::S_W){1'b0}}, pw_r[3].s2};
    x3 = {{(PW-mjpe_pkg::S_W){1'b0}}, pw_r[3].s3};
    x4 = {{(PW-mjpe_pkg::S_W){1'b0}}, pw_r[3].s4};
    x5 = {{(PW-mjpe_pkg::S_W){1'b0}}, pw_r[3].s5};
    py_nxt.start = pw_r[3].start;
    py_nxt.dmag  = pw_r[3].dmag;
    py_nxt.dneg  = pw_r[3].dneg;
    py_nxt.dur   = pw_r[3].dur;
    py_nxt.dsq   = pw_r[3].dsq;
    py_nxt.err   = pw_r[3].err;
    py_nxt.p     = mjpe_pkg::C6 * x5 - mjpe_pkg::C15 * x4 + mjpe_pkg::C10 * x3;
    py_nxt.dp    = mjpe_pkg::C30 * x4 - mjpe_pkg::C60 * x3 + mjpe_pkg::C30 * x2;
    py_nxt.ddp   = mjpe_pkg::C120 * x3 - mjpe_pkg::C180 * x2 + mjpe_pkg::C60 * x1;
  end

  // sign / magnitude split
  logic signed [PW-1:0] p_neg, dp_neg, ddp_neg;

  always_comb begin
    p_neg   = -py_r.p;
    dp_neg  = -py_r.dp;
    ddp_neg = -py_r.ddp;
    mg_nxt.start = py_r.start;
    mg_nxt.dmag  = py_r.dmag;
    mg_nxt.dur   = py_r.dur;
    mg_nxt.dsq   = py_r.dsq;
    mg_nxt.err   = py_r.err;
    mg_nxt.mp    = py_r.p[PW-1]   ? p_neg[DW-1:0]   : py_r.p[DW-1:0];
    mg_nxt.mv    = py_r.dp[PW-1]  ? dp_neg[DW-1:0]  : py_r.dp[DW-1:0];
    mg_nxt.ma    = py_r.ddp[PW-1] ? ddp_neg[mjpe_pkg::MAGA_W-1:0] :
                                    py_r.ddp[mjpe_pkg::MAGA_W-1:0];
    mg_nxt.np    = py_r.p[PW-1]   ^ py_r.dneg;
    mg_nxt.nv    = py_r.dp[PW-1]  ^ py_r.dneg;
    mg_nxt.na    = py_r.ddp[PW-1] ^ py_r.dneg;
  end

  // magnitude products
  always_comb begin
    pr_nxt.start = mg_r.start;
    pr_nxt.dur   = mg_r.dur;
    pr_nxt.dsq   = mg_r.dsq;
    pr_nxt.err   = mg_r.err;
    pr_nxt.np    = mg_r.np;
    pr_nxt.nv    = mg_r.nv;
    pr_nxt.na    = mg_r.na;
    pr_nxt.prp   = {{DW{1'b0}}, mg_r.mp} * {{DW{1'b0}}, mg_r.dmag};
    pr_nxt.prv   = {{DW{1'b0}}, mg_r.mv} * {{DW{1'b0}}, mg_r.dmag};
    pr_nxt.pra   = {{DW{1'b0}}, mg_r.ma} * {{mjpe_pkg::MAGA_W{1'b0}}, mg_r.dmag};
  end

  // position sum, scaled numerators, overflow checks; then the quotient steps
  logic signed [WW-1:0]        pos_t;
  logic signed [WW-1:0]        pos_s;
  logic signed [WW-1:0]        pos_sum;
  logic [mjpe_pkg::PROD_W-1:0] nvf;
  logic [NA_W-1:0]             naf;
  logic [DW:0]                 topv;
  logic [NA_W-QW-1:0]          topa;

  always_comb begin
    pos_t   = {{(WW-(mjpe_pkg::PROD_W-mjpe_pkg::S_BITS)){1'b0}},
               pr_r.prp[mjpe_pkg::PROD_W-1:mjpe_pkg::S_BITS]};
    pos_s   = pr_r.np ? -pos_t : pos_t;
    pos_sum = {{(WW-DW){pr_r.start[DW-1]}}, pr_r.start} + pos_s;
    nvf     = pr_r.prv >> SHV;
    naf     = (NA_W'(pr_r.pra) << SHL) >> SHR;
    topv    = nvf[mjpe_pkg::PROD_W-1:QW];
    topa    = naf[NA_W-1:QW];
    qd_nxt[0].pos  = mjpe_pkg::sat_word(pos_sum);
    qd_nxt[0].err  = pr_r.err;
    qd_nxt[0].nv   = pr_r.nv;
    qd_nxt[0].na   = pr_r.na;
    qd_nxt[0].dur  = pr_r.dur;
    qd_nxt[0].dsq  = pr_r.dsq;
    // quotient reaches 2^31 exactly when the numerator's top part reaches the divisor
    qd_nxt[0].ov_v = (topv >= {1'b0, pr_r.dur});
    qd_nxt[0].ov_a = (mjpe_pkg::DSQ_W'(topa) >= pr_r.dsq);
    qd_nxt[0].rv   = topv[DW-1:0];
    qd_nxt[0].ra   = mjpe_pkg::DSQ_W'(topa);
    qd_nxt[0].qv   = '0;
    qd_nxt[0].qa   = '0;
    qd_nxt[0].lv   = nvf[QW-1:0];
    qd_nxt[0].la   = naf[QW-1:0];
    for (int k = 1; k < QD_N; k++) begin
      qd_nxt[k] = mjpe_pkg::qdiv_step(qd_r[k-1]);
    end
  end

  // signs, saturation, error masking
  logic [DW-1:0]        vmag, amag;
  logic signed [WW-1:0] vw, aw;

  always_comb begin
    vmag = qd_r[QD_N-1].ov_v ? mjpe_pkg::MAG_OVF : {1'b0, qd_r[QD_N-1].qv};
    amag = qd_r[QD_N-1].ov_a ? mjpe_pkg::MAG_OVF : {1'b0, qd_r[QD_N-1].qa};
    vw   = {{(WW-DW){1'b0}}, vmag};
    aw   = {{(WW-DW){1'b0}}, amag};
    if (qd_r[QD_N-1].nv) begin
      vw = -vw;
    end
    if (qd_r[QD_N-1].na) begin
      aw = -aw;
    end
    if (qd_r[QD_N-1].err) begin
      fin_res.pos = '0;
      fin_res.vel = '0;
      fin_res.acc = '0;
      fin_res.err = 1'b1;
    end else begin
      fin_res.pos = qd_r[QD_N-1].pos;
      fin_res.vel = mjpe_pkg::sat_word(vw);
      fin_res.acc = mjpe_pkg::sat_word(aw);
      fin_res.err = 1'b0;
    end
  end

  // output register plus spare; the pipeline moves while the spare is empty
  assign en       = !spare_v_r;
  assign in_ready = en;
  assign arrive   = en && v_r[NS-1];

  always_comb begin
    out_v_nxt     = out_v_r;
    out_res_nxt   = out_res_r;
    spare_v_nxt   = spare_v_r;
    spare_res_nxt = spare_res_r;
    if (!out_v_r || out_ready) begin
      if (spare_v_r) begin
        out_v_nxt   = 1'b1;
        out_res_nxt = spare_res_r;
        spare_v_nxt = 1'b0;
      end else begin
        out_v_nxt   = arrive;
        out_res_nxt = fin_res;
      end
    end else if (arrive) begin
      spare_v_nxt   = 1'b1;
      spare_res_nxt = fin_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r       <= '0;
      out_v_r   <= 1'b0;
      spare_v_r <= 1'b0;
    end else begin
      if (en) begin
        v_r <= {v_r[NS-2:0], in_valid};
      end
      out_v_r   <= out_v_nxt;
      spare_v_r <= spare_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_r <= sd_nxt;
      pw_r <= pw_nxt;
      py_r <= py_nxt;
      mg_r <= mg_nxt;
      pr_r <= pr_nxt;
      qd_r <= qd_nxt;
    end
    out_res_r   <= out_res_nxt;
    spare_res_r <= spare_res_nxt;
  end

  assign out_valid        = out_v_r;
  assign out_position     = out_res_r.pos;
  assign out_velocity     = out_res_r.vel;
  assign out_acceleration = out_res_r.acc;
  assign out_time_error   = out_res_r.err;

endmodule

// ===== rtl/mjpe_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the minimum-jerk evaluator, bound to the top level.
// Uses assert_macros.svh and mjpe_pkg.
`include "assert_macros.svh"

module mjpe_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic signed [mjpe_pkg::DATA_W-1:0] in_start_value,
  input logic signed [mjpe_pkg::DATA_W-1:0] in_end_value,
  input logic [mjpe_pkg::DATA_W-1:0]        in_elapsed_time,
  input logic [mjpe_pkg::DATA_W-1:0]        in_segment_duration,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [mjpe_pkg::DATA_W-1:0] out_position,
  input logic signed [mjpe_pkg::DATA_W-1:0] out_velocity,
  input logic signed [mjpe_pkg::DATA_W-1:0] out_acceleration,
  input logic                               out_time_error
);

  // a stalled result stays up and unchanged
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable({out_position, out_velocity, out_acceleration, out_time_error}))

  // time error forces all motion outputs to zero
  `ASSERT_SAME(a_err_zero, out_valid && out_time_error, {out_position, out_velocity, out_acceleration} == '0)

  // input side only blocks once the spare holds an item behind a waiting result
  `ASSERT_SAME(a_block_needs_out, !in_ready, out_valid)

endmodule

bind minimum_jerk_point_evaluator mjpe_checker u_mjpe_checker (.*);
